// ----- rtl/clp_pkg.sv -----
package clp_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 3 * ChanW;
  localparam int unsigned LabelW = 8;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [LabelW-1:0] label;
  } entry_t;

endpackage

// ----- rtl/clp_pixel_if.sv -----
interface clp_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [clp_pkg::ChanW-1:0]  blue;
  logic [clp_pkg::ChanW-1:0]  green;
  logic [clp_pkg::ChanW-1:0]  red;
  logic                       end_of_image;

  modport source (output valid, blue, green, red, end_of_image, input ready);
  modport sink   (input valid, blue, green, red, end_of_image, output ready);
endinterface

// ----- rtl/clp_label_if.sv -----
interface clp_label_if;
  logic                       valid;
  logic                       ready;
  logic [clp_pkg::LabelW-1:0] label;
  logic                       is_new;
  logic                       table_full;
  logic                       last_out;

  modport source (output valid, label, is_new, table_full, last_out, input ready);
  modport sink   (input valid, label, is_new, table_full, last_out, output ready);
endinterface

// ----- rtl/color_to_label_palette.sv -----
// Channel   Direction  Contents
// pixel_i   in         blue, green, red, end_of_image
// label_o   out        label, is_new, table_full, last_out
//
// A pixel first reads its hash bucket from the single-port palette memory, then it is
// compared and written back. Each occupied bucket that holds another color adds a
// step on to a read of the next bucket. Black is answered without a palette entry.
// Reset empties the palette through per-bucket valid bits, so no clearing pass is run.
// A request waits in the compare cycle while the output register holds an untaken result.
module color_to_label_palette #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input logic            clk_i,
  input logic            rst_ni,
  clp_pixel_if.sink      pixel_i,
  clp_label_if.source    label_o
);

  localparam int unsigned IdxW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned Buckets = 2 ** IdxW;
  localparam int unsigned CntW    = $clog2(TABLE_DEPTH + 1);

  clp_pkg::state_e state_q, state_d;

  logic [clp_pkg::ColorW-1:0] color_q;
  logic [clp_pkg::ColorW-1:0] in_color;
  logic                       eoi_q;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [IdxW-1:0]            hash_idx;
  logic [IdxW-1:0]            rd_addr;
  logic                       rd_en;
  logic                       we;
  logic [CntW-1:0]            count_q, count_d;
  logic [Buckets-1:0]         valid_q;
  clp_pkg::entry_t            mem_q [Buckets];
  clp_pkg::entry_t            rd_q;

  logic                       out_free;
  logic                       done;
  logic                       fire;
  logic [clp_pkg::LabelW-1:0] res_label;
  logic                       res_new;
  logic                       res_full;

  logic                       out_valid_q;
  logic [clp_pkg::LabelW-1:0] out_label_q;
  logic                       out_new_q;
  logic                       out_full_q;
  logic                       out_last_q;

  assign in_color = {pixel_i.red, pixel_i.green, pixel_i.blue};
  assign pixel_i.ready = (state_q == clp_pkg::StIdle);
  assign out_free = !out_valid_q || label_o.ready;
  assign fire = done && out_free;

  always_comb begin
    hash_idx = '0;
    for (int i = 0; i < clp_pkg::ColorW; i++) begin
      hash_idx[i % IdxW] = hash_idx[i % IdxW] ^ in_color[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    we        = 1'b0;
    done      = 1'b0;
    res_label = '0;
    res_new   = 1'b0;
    res_full  = 1'b0;
    case (state_q)
      clp_pkg::StIdle: begin
        if (pixel_i.valid) begin
          rd_en   = 1'b1;
          rd_addr = hash_idx;
          idx_d   = hash_idx;
          state_d = clp_pkg::StRead;
        end
      end
      clp_pkg::StRead: begin
        if (color_q == '0) begin
          done = 1'b1;
        end else if (valid_q[idx_q] && rd_q.color == color_q) begin
          done      = 1'b1;
          res_label = rd_q.label;
        end else if (valid_q[idx_q]) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end else if (count_q == CntW'(TABLE_DEPTH)) begin
          done     = 1'b1;
          res_full = 1'b1;
        end else begin
          done      = 1'b1;
          res_new   = 1'b1;
          res_label = clp_pkg::LabelW'(count_q);
          we        = out_free;
          if (out_free) begin
            count_d = count_q + CntW'(1);
          end
        end
        if (fire) begin
          state_d = clp_pkg::StIdle;
        end
      end
      default: begin
        state_d = clp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clp_pkg::StIdle;
      count_q <= CntW'(1);
      valid_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_i.valid && pixel_i.ready) begin
      color_q <= in_color;
      eoi_q   <= pixel_i.end_of_image;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[idx_q] <= '{color: color_q, label: res_label};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_label_q <= res_label;
      out_new_q   <= res_new;
      out_full_q  <= res_full;
      out_last_q  <= eoi_q;
    end
  end

  assign label_o.valid      = out_valid_q;
  assign label_o.label      = out_label_q;
  assign label_o.is_new     = out_new_q;
  assign label_o.table_full = out_full_q;
  assign label_o.last_out   = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CntW'(TABLE_DEPTH)))
    else $error("palette entry count out of range");

  a_valid_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q) + 1) == int'(count_q))
    else $error("occupied buckets disagree with entry count");

  a_write_empty_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !valid_q[idx_q] && (color_q != '0))
    else $error("insert into an occupied bucket or of black");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_new_q && out_full_q))
    else $error("result flagged both new and full");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clp_pkg::StRead) && !fire |=> state_q == clp_pkg::StRead)
    else $error("request left compare stage without a result");
`endif

endmodule
